// ----- hdl/smx_pkg.sv -----
package smx_pkg;

	// Data word and stack geometry.
	localparam int WORD_W      = 32;
	localparam int STACK_DEPTH = 128;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int CNT_W       = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] MIN_WORD = {1'b1, {(WORD_W-1){1'b0}}};

	// Instruction codes.
	typedef enum logic [4:0] {
		OP_NOP   = 5'd0,
		OP_PUSH  = 5'd1,
		OP_POP   = 5'd2,
		OP_COPY  = 5'd3,
		OP_PRINT = 5'd4,
		OP_HALT  = 5'd5,
		OP_ADD   = 5'd6,
		OP_SUB   = 5'd7,
		OP_QUOT  = 5'd8,
		OP_REM   = 5'd9,
		OP_AND   = 5'd10,
		OP_OR    = 5'd11,
		OP_NOT   = 5'd12,
		OP_EQ    = 5'd13,
		OP_NE    = 5'd14,
		OP_LT    = 5'd15,
		OP_LE    = 5'd16,
		OP_GT    = 5'd17,
		OP_GE    = 5'd18
	} opcode_t;

	// Error codes reported with each result.
	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNDERFLOW = 2'd2,
		ERR_DIVZERO   = 2'd3
	} err_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_DIV,
		ST_WB
	} state_t;

	// Divider request and response.
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quotient;
		logic [WORD_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ----- hdl/stack_machine_execute_core.sv -----
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   opcode, immediate
// out      output     out_valid / out_stall top_value, stack_count, print_valid,
//                                           halted, error_code
//
// Most instructions pass from acceptance to result through accept, stack read,
// execute and write back.
// Quotient and remainder add a divide step between execute and write back, set by
// the radix-2 divider that produces one quotient bit per cycle.
// Reset empties the stack and clears the halt flag; stack memory is not cleared.
// A stalled result holds the write back until the output register is free,
// and a new transaction is taken only while the sequencer is idle.
module stack_machine_execute_core import smx_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [4:0]               opcode,
	input  logic signed [WORD_W-1:0] immediate,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] top_value,
	output logic [7:0]               stack_count,
	output logic                     print_valid,
	output logic                     halted,
	output logic [1:0]               error_code
);

	state_t state_q, state_d;

	// Architectural state.
	logic [SP_W-1:0]   sp_q;
	logic [WORD_W-1:0] top_q;
	logic              halt_q;
	logic [WORD_W-1:0] mem [STACK_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// Latched instruction.
	logic [4:0]        op_q;
	logic [WORD_W-1:0] imm_q;

	// Results of the execute step, committed in write back.
	logic [SP_W-1:0]   nsp_q;
	logic [WORD_W-1:0] ntop_q;
	logic              wr_q;
	logic [ADDR_W-1:0] waddr_q;
	err_t              err_q;
	logic              prn_q;
	logic              nhalt_q;
	logic              lneg_q;
	logic              rneg_q;
	logic              isquot_q;

	// Output register.
	logic              out_valid_q;
	logic [WORD_W-1:0] out_top_q;
	logic [7:0]        out_count_q;
	logic              out_print_q;
	logic              out_halt_q;
	err_t              out_err_q;

	// Execute step combinational results.
	logic              sp_ge1;
	logic              sp_ge2;
	logic              full;
	logic [SP_W-1:0]   sp_m1;
	logic [SP_W-1:0]   sp_m2;
	logic [WORD_W-1:0] r_val;
	logic [WORD_W-1:0] l_val;
	logic [WORD_W-1:0] alu_res;
	logic              lt_lr;
	logic              lt_rl;
	logic              under;
	logic              over;
	logic              divz;
	logic              div_go;
	logic [SP_W-1:0]   nsp_d;
	logic [WORD_W-1:0] ntop_d;
	logic              wr_d;
	logic [ADDR_W-1:0] waddr_d;
	logic              prn_d;
	logic              nhalt_d;
	err_t              err_d;
	logic [ADDR_W-1:0] rd_addr;
	logic              commit;
	logic [WORD_W-1:0] div_fix;

	div_req_t div_req;
	div_rsp_t div_rsp;

	smx_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign commit   = (state_q == ST_WB) && (!out_valid_q || !out_stall);
	assign rd_addr  = ADDR_W'(sp_q - SP_W'(2));

	// Operand selection; an empty slot reads as the minimum word.
	always_comb begin
		sp_ge1 = (sp_q != '0);
		sp_ge2 = (sp_q > SP_W'(1));
		full   = (sp_q >= SP_W'(STACK_DEPTH));
		sp_m1  = sp_ge1 ? sp_q - SP_W'(1) : '0;
		sp_m2  = sp_ge2 ? sp_q - SP_W'(2) : '0;
		r_val  = sp_ge1 ? top_q : MIN_WORD;
		l_val  = sp_ge2 ? rdata_q : MIN_WORD;
		lt_lr  = ($signed(l_val) < $signed(r_val));
		lt_rl  = ($signed(r_val) < $signed(l_val));
	end

	// Two-operand arithmetic, logic and compare.
	always_comb begin
		alu_res = '0;
		unique case (op_q)
			OP_ADD:  alu_res = l_val + r_val;
			OP_SUB:  alu_res = l_val - r_val;
			OP_AND:  alu_res = {{(WORD_W-1){1'b0}}, (l_val != '0) && (r_val != '0)};
			OP_OR:   alu_res = {{(WORD_W-1){1'b0}}, (l_val != '0) || (r_val != '0)};
			OP_EQ:   alu_res = {{(WORD_W-1){1'b0}}, l_val == r_val};
			OP_NE:   alu_res = {{(WORD_W-1){1'b0}}, l_val != r_val};
			OP_LT:   alu_res = {{(WORD_W-1){1'b0}}, lt_lr};
			OP_LE:   alu_res = {{(WORD_W-1){1'b0}}, !lt_rl};
			OP_GT:   alu_res = {{(WORD_W-1){1'b0}}, lt_rl};
			OP_GE:   alu_res = {{(WORD_W-1){1'b0}}, !lt_lr};
			default: alu_res = '0;
		endcase
	end

	// Instruction decode: new stack pointer, new top, stack write, print, halt and error.
	always_comb begin
		nsp_d   = sp_q;
		ntop_d  = top_q;
		wr_d    = 1'b0;
		waddr_d = ADDR_W'(sp_q);
		prn_d   = 1'b0;
		nhalt_d = halt_q;
		under   = 1'b0;
		over    = 1'b0;
		divz    = 1'b0;
		div_go  = 1'b0;
		if (!halt_q) begin
			unique case (op_q)
				OP_PUSH: begin
					if (full) begin
						over = 1'b1;
					end else begin
						wr_d   = 1'b1;
						ntop_d = imm_q;
						nsp_d  = sp_q + SP_W'(1);
					end
				end
				OP_POP: begin
					under  = !sp_ge1;
					nsp_d  = sp_m1;
					ntop_d = rdata_q;
				end
				OP_COPY: begin
					under = !sp_ge1;
					if (full) begin
						over = 1'b1;
					end else begin
						wr_d   = 1'b1;
						ntop_d = r_val;
						nsp_d  = sp_q + SP_W'(1);
					end
				end
				OP_PRINT: begin
					under = !sp_ge1;
					prn_d = 1'b1;
				end
				OP_HALT: begin
					nhalt_d = 1'b1;
				end
				OP_NOT: begin
					under   = !sp_ge1;
					wr_d    = 1'b1;
					waddr_d = ADDR_W'(sp_m1);
					nsp_d   = sp_m1 + SP_W'(1);
					ntop_d  = {{(WORD_W-1){1'b0}}, r_val == '0};
				end
				OP_ADD, OP_SUB, OP_AND, OP_OR, OP_EQ, OP_NE,
				OP_LT, OP_LE, OP_GT, OP_GE: begin
					under   = !sp_ge2;
					wr_d    = 1'b1;
					waddr_d = ADDR_W'(sp_m2);
					nsp_d   = sp_m2 + SP_W'(1);
					ntop_d  = alu_res;
				end
				OP_QUOT, OP_REM: begin
					under   = !sp_ge2;
					wr_d    = 1'b1;
					waddr_d = ADDR_W'(sp_m2);
					nsp_d   = sp_m2 + SP_W'(1);
					ntop_d  = '0;
					divz    = (r_val == '0);
					div_go  = !divz;
				end
				default: begin
				end
			endcase
		end
		priority if (under) begin
			err_d = ERR_UNDERFLOW;
		end else if (divz) begin
			err_d = ERR_DIVZERO;
		end else if (over) begin
			err_d = ERR_OVERFLOW;
		end else begin
			err_d = ERR_NONE;
		end
	end

	// Divider operands are magnitudes; signs are restored afterwards.
	always_comb begin
		div_req.start    = (state_q == ST_EXEC) && div_go;
		div_req.dividend = l_val[WORD_W-1] ? WORD_W'(0) - l_val : l_val;
		div_req.divisor  = r_val[WORD_W-1] ? WORD_W'(0) - r_val : r_val;
	end

	always_comb begin
		if (isquot_q) begin
			div_fix = (lneg_q != rneg_q) ? WORD_W'(0) - div_rsp.quotient
			                             : div_rsp.quotient;
		end else begin
			div_fix = lneg_q ? WORD_W'(0) - div_rsp.remainder : div_rsp.remainder;
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_EXEC;
			ST_EXEC:  state_d = div_go ? ST_DIV : ST_WB;
			ST_DIV:   if (div_rsp.done) state_d = ST_WB;
			ST_WB:    if (commit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Stack memory: second entry read ahead of execute, result written back.
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			rdata_q <= mem[rd_addr];
		end
		if (commit && wr_q) begin
			mem[waddr_q] <= ntop_q;
		end
	end

	// Instruction latch and execute results.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q  <= opcode;
			imm_q <= immediate;
		end
		if (state_q == ST_EXEC) begin
			nsp_q    <= nsp_d;
			ntop_q   <= ntop_d;
			wr_q     <= wr_d;
			waddr_q  <= waddr_d;
			err_q    <= err_d;
			prn_q    <= prn_d;
			nhalt_q  <= nhalt_d;
			lneg_q   <= l_val[WORD_W-1];
			rneg_q   <= r_val[WORD_W-1];
			isquot_q <= (op_q == OP_QUOT);
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			ntop_q <= div_fix;
		end
		if (commit) begin
			top_q       <= ntop_q;
			out_top_q   <= (nsp_q == '0) ? MIN_WORD : ntop_q;
			out_count_q <= 8'(nsp_q);
			out_print_q <= prn_q;
			out_halt_q  <= nhalt_q;
			out_err_q   <= err_q;
		end
	end

	// Control state: stack pointer, halt flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				sp_q        <= nsp_q;
				halt_q      <= nhalt_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign top_value   = out_top_q;
	assign stack_count = out_count_q;
	assign print_valid = out_print_q;
	assign halted      = out_halt_q;
	assign error_code  = out_err_q;

	// The stack pointer never passes the stack depth.
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	// Halt is sticky until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared without reset");

	// The divider only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	// A dropped push or copy is reported only on a full stack.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q == ERR_OVERFLOW) |-> out_count_q == 8'(STACK_DEPTH))
		else $error("overflow reported on a stack that is not full");

	// A halted machine leaves the stack pointer alone.
	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && halt_q) |=> $stable(sp_q))
		else $error("stack changed while halted");

endmodule

// ----- hdl/smx_divider.sv -----
module smx_divider import smx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;

	// Restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		shifted = {rem_q, quo_q[WORD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
	end

	// Control: start loads the operands, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers for partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
